>>> rtl/core/aszc_pkg.sv
// Shared types, constants and helpers for the analog stick zone classifier.
// No dependencies; every other file in rtl/core imports this package.
package aszc_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = SAMPLE_BITS - 1;
    localparam int ZONE_COUNT     = 5;
    localparam int ZONE_BITS      = 3;
    localparam int MARKER_REGS    = 5;
    localparam int MARKER_BITS    = 16;
    localparam int MARKER_IDX_BITS = $clog2(MARKER_REGS);
    localparam int CMP_BITS       = (SAMPLE_BITS > MARKER_BITS) ? SAMPLE_BITS : MARKER_BITS;

    localparam int REG_INDEX_BITS = 3;
    localparam int CFG_ADDR_BITS  = REG_INDEX_BITS + 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [REG_INDEX_BITS-1:0] REG_HOLD_FIRST  = 3'd5;
    localparam logic [REG_INDEX_BITS-1:0] REG_HOLD_SECOND = 3'd6;

    localparam logic [SAMPLE_BITS-1:0] MAG_ONE = SAMPLE_BITS'(1) << FRAC_BITS;

    localparam logic [MARKER_REGS-1:0][MARKER_BITS-1:0] MARKER_RESET = {
        16'd32768, 16'd24576, 16'd16384, 16'd6554, 16'd3932
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] stick_x;
        logic signed [SAMPLE_BITS-1:0] stick_y;
        logic                          input_allowed;
    } sample_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] magnitude;
        logic [ZONE_BITS-1:0]   zone_index;
        logic [SAMPLE_BITS-1:0] zone_fraction;
        logic                   suppressed;
    } result_t;

    typedef struct packed {
        logic [MARKER_REGS-1:0][MARKER_BITS-1:0] marker;
        logic                                    hold_first;
        logic                                    hold_second;
    } cfg_t;

    // Zones past the programmable markers have their upper bound fixed at 1.0.
    function automatic logic [CMP_BITS-1:0] marker_at(input cfg_t cfg, input int k);
        logic [CMP_BITS-1:0] value;
        if (k < MARKER_REGS)
            value = CMP_BITS'(cfg.marker[MARKER_IDX_BITS'(k)]);
        else
            value = CMP_BITS'(MAG_ONE);
        return value;
    endfunction

endpackage

>>> rtl/core/aszc_regs.sv
// Configuration register file: zone markers and the two hold bits behind an APB port.
// Depends on aszc_pkg.
module aszc_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [aszc_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [aszc_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [aszc_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output aszc_pkg::cfg_t                       cfg
);
    import aszc_pkg::*;

    logic [REG_INDEX_BITS-1:0] reg_index;
    logic                      wr_en;
    cfg_t                      cfg_reg;
    cfg_t                      cfg_next;

    assign reg_index = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            if (32'(reg_index) < MARKER_REGS)
                cfg_next.marker[MARKER_IDX_BITS'(reg_index)] = pwdata[MARKER_BITS-1:0];
            else if (reg_index == REG_HOLD_FIRST)
                cfg_next.hold_first = pwdata[0];
            else if (reg_index == REG_HOLD_SECOND)
                cfg_next.hold_second = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.marker      <= MARKER_RESET;
            cfg_reg.hold_first  <= 1'b0;
            cfg_reg.hold_second <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (32'(reg_index) < MARKER_REGS)
            prdata = CFG_DATA_BITS'(cfg_reg.marker[MARKER_IDX_BITS'(reg_index)]);
        else if (reg_index == REG_HOLD_FIRST)
            prdata = CFG_DATA_BITS'(cfg_reg.hold_first);
        else if (reg_index == REG_HOLD_SECOND)
            prdata = CFG_DATA_BITS'(cfg_reg.hold_second);
    end

endmodule

>>> rtl/core/aszc_mag.sv
// Bit-serial magnitude unit: x*x + y*y by shift-and-add, then a digit-by-digit
// integer square root taking two radicand bits per cycle. Depends on aszc_pkg.
module aszc_mag (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [aszc_pkg::SAMPLE_BITS-1:0]   ax,
    input  logic [aszc_pkg::SAMPLE_BITS-1:0]   ay,
    output logic                               done,
    output logic [aszc_pkg::SAMPLE_BITS-1:0]   root
);
    import aszc_pkg::*;

    localparam int SQ_BITS  = 2 * SAMPLE_BITS;
    localparam int REM_BITS = SAMPLE_BITS + 3;
    localparam int CNT_BITS = $clog2(SAMPLE_BITS);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(SAMPLE_BITS - 1);

    logic                   busy_reg, busy_next;
    logic                   root_phase_reg, root_phase_next;
    logic                   done_reg, done_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] ax_reg, ax_next;
    logic [SAMPLE_BITS-1:0] ay_reg, ay_next;
    logic [SAMPLE_BITS-1:0] xs_reg, xs_next;
    logic [SAMPLE_BITS-1:0] ys_reg, ys_next;
    logic [SQ_BITS-1:0]     acc_reg, acc_next;
    logic [REM_BITS-1:0]    rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] root_reg, root_next;

    logic [REM_BITS-1:0]    rem_shift;
    logic [REM_BITS-1:0]    trial;

    assign rem_shift = {rem_reg[REM_BITS-3:0], acc_reg[SQ_BITS-1 -: 2]};
    assign trial     = REM_BITS'({root_reg, 2'b01});

    always_comb
    begin
        busy_next       = busy_reg;
        root_phase_next = root_phase_reg;
        done_next       = 1'b0;
        cnt_next        = cnt_reg;
        ax_next         = ax_reg;
        ay_next         = ay_reg;
        xs_next         = xs_reg;
        ys_next         = ys_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        root_next       = root_reg;
        if (start)
        begin
            busy_next       = 1'b1;
            root_phase_next = 1'b0;
            cnt_next        = '0;
            ax_next         = ax;
            ay_next         = ay;
            xs_next         = ax;
            ys_next         = ay;
            acc_next        = '0;
            rem_next        = '0;
            root_next       = '0;
        end
        else if (busy_reg && !root_phase_reg)
        begin
            // Multiplier bits are consumed from the top, so the sum doubles each step.
            acc_next = (acc_reg << 1)
                     + (xs_reg[SAMPLE_BITS-1] ? SQ_BITS'(ax_reg) : '0)
                     + (ys_reg[SAMPLE_BITS-1] ? SQ_BITS'(ay_reg) : '0);
            xs_next  = xs_reg << 1;
            ys_next  = ys_reg << 1;
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == LAST)
            begin
                root_phase_next = 1'b1;
                cnt_next        = '0;
            end
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg << 2;
            if (rem_shift >= trial)
            begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[SAMPLE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift;
                root_next = {root_reg[SAMPLE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            root_phase_reg <= 1'b0;
            done_reg       <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            root_phase_reg <= root_phase_next;
            done_reg       <= done_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        xs_reg   <= xs_next;
        ys_reg   <= ys_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/core/aszc_div.sv
// Bit-serial restoring divider for the in-zone position, one quotient bit per cycle.
// The dividend never exceeds the divisor, so the quotient is at most 1.0. Depends on aszc_pkg.
module aszc_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [aszc_pkg::CMP_BITS-1:0]      dividend,
    input  logic [aszc_pkg::CMP_BITS-1:0]      divisor,
    output logic                               done,
    output logic [aszc_pkg::SAMPLE_BITS-1:0]   quotient
);
    import aszc_pkg::*;

    localparam int CNT_BITS = $clog2(FRAC_BITS);
    localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(FRAC_BITS - 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [CMP_BITS-1:0]    rem_reg, rem_next;
    logic [CMP_BITS-1:0]    den_reg, den_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;

    logic [CMP_BITS:0]      rem_shift;

    assign rem_shift = {rem_reg, 1'b0};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            // The integer part is one only when the magnitude sits on the upper bound.
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = divisor;
            if (dividend >= divisor)
            begin
                quo_next = SAMPLE_BITS'(1);
                rem_next = '0;
            end
            else
            begin
                quo_next = '0;
                rem_next = dividend;
            end
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = CMP_BITS'(rem_shift - {1'b0, den_reg});
                quo_next = {quo_reg[SAMPLE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[CMP_BITS-1:0];
                quo_next = {quo_reg[SAMPLE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/analog_stick_zone_classifier_top.sv
// Analog stick zone classifier: one request at a time. Every request passes through the
// bit-serial magnitude unit, and through the bit-serial divider unless no division is needed
// (suppressed, dead zone or no zone match). The result waits while an earlier one is not yet
// taken, and the next request can be taken in the same cycle that the result appears.
// Reset (rst_n, asynchronous, active low) restores the marker defaults, clears the holds
// and held zone, and marks the first request after reset for suppression.
module analog_stick_zone_classifier_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [aszc_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [aszc_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [aszc_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  aszc_pkg::sample_t                    sample,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output aszc_pkg::result_t                    result
);
    import aszc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAG   = 3'd1;
    localparam logic [2:0] ST_CLASS = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    cfg_t                   cfg;
    logic                   accept;
    logic                   supp_now;
    logic [SAMPLE_BITS-1:0] x_bits, y_bits;
    logic [SAMPLE_BITS-1:0] ax, ay;
    logic [SAMPLE_BITS-1:0] ax_in, ay_in;
    logic                   mag_done;
    logic [SAMPLE_BITS-1:0] root;
    logic                   div_start;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] quotient;

    logic [CMP_BITS-1:0]    mag_ext;
    logic                   in_dead_zone;
    logic                   zone_hit;
    logic [ZONE_BITS-1:0]   zone_sel;
    logic [CMP_BITS-1:0]    lo_sel, hi_sel;
    logic [CMP_BITS-1:0]    lo_k, hi_k;

    logic [2:0]             state_reg, state_next;
    logic                   first_pending_reg, first_pending_next;
    logic                   supp_reg, supp_next;
    logic [SAMPLE_BITS-1:0] mag_reg, mag_next;
    logic [ZONE_BITS-1:0]   zone_sel_reg, zone_sel_next;
    logic [ZONE_BITS-1:0]   held_idx_reg, held_idx_next;
    logic [SAMPLE_BITS-1:0] held_frac_reg, held_frac_next;
    logic                   result_valid_reg, result_valid_next;
    result_t                result_reg, result_next;

    aszc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign supp_now     = cfg.hold_first || cfg.hold_second || first_pending_reg
                          || !sample.input_allowed;

    assign x_bits = sample.stick_x;
    assign y_bits = sample.stick_y;
    assign ax     = x_bits[SAMPLE_BITS-1] ? (~x_bits + SAMPLE_BITS'(1)) : x_bits;
    assign ay     = y_bits[SAMPLE_BITS-1] ? (~y_bits + SAMPLE_BITS'(1)) : y_bits;
    assign ax_in  = supp_now ? '0 : ax;
    assign ay_in  = supp_now ? '0 : ay;

    aszc_mag u_mag (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .ax    (ax_in),
        .ay    (ay_in),
        .done  (mag_done),
        .root  (root)
    );

    // Zone search: the lowest matching zone wins, so scan from the top down.
    always_comb
    begin
        mag_ext      = CMP_BITS'(mag_reg);
        in_dead_zone = (mag_ext <= marker_at(cfg, 0));
        zone_hit     = 1'b0;
        zone_sel     = '0;
        lo_sel       = '0;
        hi_sel       = '0;
        lo_k         = '0;
        hi_k         = '0;
        for (int k = ZONE_COUNT - 1; k >= 1; k--)
        begin
            lo_k = marker_at(cfg, k - 1);
            hi_k = marker_at(cfg, k);
            if ((lo_k < mag_ext) && (mag_ext <= hi_k))
            begin
                zone_hit = 1'b1;
                zone_sel = ZONE_BITS'(k);
                lo_sel   = lo_k;
                hi_sel   = hi_k;
            end
        end
    end

    assign div_start = (state_reg == ST_CLASS) && !in_dead_zone && zone_hit;

    aszc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_ext - lo_sel),
        .divisor  (hi_sel - lo_sel),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next         = state_reg;
        first_pending_next = first_pending_reg;
        supp_next          = supp_reg;
        mag_next           = mag_reg;
        zone_sel_next      = zone_sel_reg;
        held_idx_next      = held_idx_reg;
        held_frac_next     = held_frac_reg;
        result_valid_next  = result_valid_reg;
        result_next        = result_reg;
        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    supp_next = supp_now;
                    if (supp_now)
                        first_pending_next = 1'b0;
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                if (mag_done)
                begin
                    mag_next   = (root > MAG_ONE) ? MAG_ONE : root;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                if (in_dead_zone)
                begin
                    held_idx_next  = '0;
                    held_frac_next = '0;
                    state_next     = ST_OUT;
                end
                else if (zone_hit)
                begin
                    zone_sel_next = zone_sel;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    held_idx_next  = zone_sel_reg;
                    held_frac_next = quotient;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.magnitude     = mag_reg;
                    result_next.zone_index    = held_idx_reg;
                    result_next.zone_fraction = held_frac_reg;
                    result_next.suppressed    = supp_reg;
                    result_valid_next         = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            first_pending_reg <= 1'b1;
            held_idx_reg      <= '0;
            held_frac_reg     <= '0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            first_pending_reg <= first_pending_next;
            held_idx_reg      <= held_idx_next;
            held_frac_reg     <= held_frac_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        supp_reg     <= supp_next;
        mag_reg      <= mag_next;
        zone_sel_reg <= zone_sel_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_mag_done_in_mag: assert property (@(posedge clk) disable iff (!rst_n)
        mag_done |-> state_reg == ST_MAG)
        else $error("magnitude unit finished outside the magnitude phase");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the division phase");

    a_first_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !first_pending_reg)
        else $error("first-request flag survived an accepted request");

    a_supp_zero_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.suppressed) |-> result.magnitude == '0)
        else $error("suppressed result carries a nonzero magnitude");

    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.zone_fraction <= MAG_ONE)
                         && (result.magnitude <= MAG_ONE)
                         && (result.zone_index <= ZONE_BITS'(ZONE_COUNT - 1)))
        else $error("result field out of range");

endmodule
